FILE: rtl/core/hashed_position_table_macros.svh
// assertion helpers shared by the checking code of the table
`ifndef HASHED_POSITION_TABLE_MACROS_SVH
`define HASHED_POSITION_TABLE_MACROS_SVH

// condition holds in the same cycle
`define HPT_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// condition holds in the cycle after the precondition
`define HPT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/core/hpt_pkg.sv
package hpt_pkg;

	localparam int TABLE_SLOTS = 1024;
	localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
	localparam int NUM_W       = SLOT_BITS + 1;
	localparam int MUL_W       = 32 + NUM_W;
	localparam int SUM_W       = MUL_W + 1;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 15;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AGE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd2;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_PROBE = 1'b1;

	localparam logic [NUM_W-1:0] ENTRIES_RESET = NUM_W'(1024);
	localparam logic [14:0]      THRESH_RESET  = 15'd31000;

	typedef struct packed {
		logic               req_type;
		logic [63:0]        position_key;
		logic [7:0]         ply;
		logic [15:0]        best_move;
		logic signed [15:0] eval_score;
		logic [7:0]         search_depth;
		logic [1:0]         bound_kind;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [15:0] found_score;
		logic [15:0]        found_move;
		logic [7:0]         found_depth;
		logic [1:0]         found_kind;
		logic [5:0]         found_age;
	} rsp_t;

	typedef struct packed {
		logic [15:0]        move;
		logic signed [15:0] score;
		logic [7:0]         depth;
		logic [1:0]         kind;
		logic [5:0]         age;
	} payload_t;

	// one classified request between front and back
	typedef struct packed {
		logic                 req_type;
		logic [63:0]          position_key;
		logic [7:0]           ply;
		logic [SLOT_BITS-1:0] slot;
		payload_t             payload;
	} job_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		payload_t    payload;
	} entry_t;

	typedef struct packed {
		logic               valid;
		logic [Q_CNT_W-1:0] level;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LOOK,
		BK_FIN
	} back_state_t;

	function automatic logic is_win(logic signed [15:0] s, logic [14:0] thr);
		logic signed [16:0] a;
		logic signed [16:0] b;
		a = {s[15], s};
		b = {2'b00, thr};
		return a >= b;
	endfunction

	function automatic logic is_lose(logic signed [15:0] s, logic [14:0] thr);
		logic signed [16:0] a;
		logic signed [16:0] b;
		a = {s[15], s};
		b = -{2'b00, thr};
		return a <= b;
	endfunction

	function automatic logic signed [15:0] add_ply(logic signed [15:0] s, logic [7:0] ply);
		logic signed [15:0] p;
		p = {8'h00, ply};
		return s + p;
	endfunction

	function automatic logic signed [15:0] sub_ply(logic signed [15:0] s, logic [7:0] ply);
		logic signed [15:0] p;
		p = {8'h00, ply};
		return s - p;
	endfunction

endpackage

FILE: rtl/core/hpt_front.sv
module hpt_front import hpt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	input  logic [NUM_W-1:0] entries,
	input  logic [5:0]       age,
	input  logic [14:0]      thresh,
	input  logic             enable,
	input  q_status_t        q_status,
	output logic             push,
	output job_t             push_data
);

	logic             v_s1;
	req_t             req_s1;
	payload_t         pay_s1;
	logic [MUL_W-1:0] lo_s1;
	logic [MUL_W-1:0] hi_s1;
	logic [NUM_W-1:0] n;
	logic             accept;
	logic signed [15:0] wr_score;
	logic [SUM_W-1:0] sum;

	// room for the stage in flight plus the new transaction
	assign req_ready = enable && (q_status.level <= Q_CNT_W'(Q_DEPTH - 2));
	assign accept    = req_valid && req_ready;

	assign n = (entries > NUM_W'(TABLE_SLOTS)) ? NUM_W'(TABLE_SLOTS) : entries;

	always_comb begin
		wr_score = req.eval_score;
		if (is_win(req.eval_score, thresh)) begin
			wr_score = add_ply(req.eval_score, req.ply);
		end else if (is_lose(req.eval_score, thresh)) begin
			wr_score = sub_ply(req.eval_score, req.ply);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// index is the top of key * n, split in two 32-bit halves
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1       <= req;
			pay_s1.move  <= req.best_move;
			pay_s1.score <= wr_score;
			pay_s1.depth <= req.search_depth;
			pay_s1.kind  <= req.bound_kind;
			pay_s1.age   <= age;
			lo_s1        <= MUL_W'(req.position_key[31:0]) * MUL_W'(n);
			hi_s1        <= MUL_W'(req.position_key[63:32]) * MUL_W'(n);
		end
	end

	assign sum = SUM_W'(hi_s1) + SUM_W'(lo_s1[MUL_W-1:32]);

	assign push                   = v_s1;
	assign push_data.req_type     = req_s1.req_type;
	assign push_data.position_key = req_s1.position_key;
	assign push_data.ply          = req_s1.ply;
	assign push_data.slot         = sum[32 +: SLOT_BITS];
	assign push_data.payload      = pay_s1;

endmodule

FILE: rtl/core/hpt_queue.sv
module hpt_queue import hpt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_data,
	input  logic      pop,
	output job_t      head,
	output q_status_t status
);

	job_t               slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] level_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.valid = (level_q != '0);
	assign status.level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/core/hpt_back.sv
module hpt_back import hpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        head,
	input  q_status_t   q_status,
	output logic        pop,
	input  logic [14:0] thresh,
	output logic        ready,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp
);

	entry_t               mem_q [TABLE_SLOTS];
	back_state_t          state_q;
	back_state_t          state_d;
	logic [SLOT_BITS-1:0] clr_q;
	job_t                 cur_q;
	entry_t               rdata_q;
	logic                 hit_q;
	logic signed [15:0]   adj_q;
	logic                 out_valid_q;
	rsp_t                 out_q;

	logic                 mem_we;
	logic [SLOT_BITS-1:0] mem_addr;
	entry_t               mem_wdata;
	logic                 rd_en;
	logic                 load_out;
	rsp_t                 out_d;
	logic                 out_free;
	logic                 look_hit;
	logic signed [15:0]   look_score;
	logic signed [15:0]   fin_score;

	assign out_free  = !out_valid_q || rsp_ready;
	assign ready     = (state_q != BK_CLEAR);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign look_hit   = rdata_q.valid && (rdata_q.key == cur_q.position_key);
	assign look_score = is_win(rdata_q.payload.score, thresh) ?
		sub_ply(rdata_q.payload.score, cur_q.ply) : rdata_q.payload.score;
	assign fin_score  = is_lose(adj_q, thresh) ? add_ply(adj_q, cur_q.ply) : adj_q;

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = head.slot;
		mem_wdata = '0;
		rd_en     = 1'b0;
		load_out  = 1'b0;
		out_d     = '0;
		unique case (state_q)
			BK_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				if (clr_q == '1) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_status.valid && out_free) begin
					pop = 1'b1;
					if (head.req_type == REQ_WRITE) begin
						mem_we          = 1'b1;
						mem_wdata.valid = 1'b1;
						mem_wdata.key   = head.position_key;
						mem_wdata.payload = head.payload;
						load_out        = 1'b1;
					end else begin
						rd_en   = 1'b1;
						state_d = BK_LOOK;
					end
				end
			end
			BK_LOOK: begin
				state_d = BK_FIN;
			end
			BK_FIN: begin
				load_out = 1'b1;
				if (hit_q) begin
					out_d.hit         = 1'b1;
					out_d.found_score = fin_score;
					out_d.found_move  = rdata_q.payload.move;
					out_d.found_depth = rdata_q.payload.depth;
					out_d.found_kind  = rdata_q.payload.kind;
					out_d.found_age   = rdata_q.payload.age;
				end
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (state_q == BK_LOOK) begin
			hit_q <= look_hit;
			adj_q <= look_score;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	// table storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem_q[head.slot];
		end
	end

endmodule

FILE: rtl/core/hashed_position_table.sv
// a request passes the front stage register and the queue, then a write loads the
// response register and a probe the read data, compare and response registers;
// throughput: one write per cycle while the output register is free; a probe holds
// the table port for read, compare and two score fixes; reset sets the control
// state and config registers, then a clearing pass zeroes every slot, req_ready low
module hashed_position_table import hpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "hashed_position_table_macros.svh"

	logic [NUM_W-1:0] entries_q;
	logic [5:0]       age_q;
	logic [14:0]      thresh_q;

	logic      q_push;
	job_t      q_push_data;
	logic      q_pop;
	job_t      q_head;
	q_status_t q_status;
	logic      back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
			age_q     <= '0;
			thresh_q  <= THRESH_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ENTRIES: entries_q <= cfg_data[NUM_W-1:0];
				REG_AGE:     age_q     <= cfg_data[5:0];
				REG_THRESH:  thresh_q  <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	hpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.entries   (entries_q),
		.age       (age_q),
		.thresh    (thresh_q),
		.enable    (back_ready),
		.q_status  (q_status),
		.push      (q_push),
		.push_data (q_push_data)
	);

	hpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.status    (q_status)
	);

	hpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_status  (q_status),
		.pop       (q_pop),
		.thresh    (thresh_q),
		.ready     (back_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`HPT_ASSERT_NOW(a_no_accept_in_clear, req_ready, back_ready, "request taken during clear")
	`HPT_ASSERT_NOW(a_no_overflow, q_push && !q_pop, q_status.level != Q_CNT_W'(Q_DEPTH), "queue overflow")
	`HPT_ASSERT_NOW(a_no_underflow, q_pop, q_status.valid, "queue underflow")
	`HPT_ASSERT_NEXT(a_accept_pushes, req_valid && req_ready, q_push, "accepted request not queued")

endmodule
